/* rtl/core/fbrr_pkg.sv */
// shared types, codes and default parameters of the queue bank
package fbrr_pkg;

    // default sizes of the bank
    localparam int NUM_QUEUES_DEF = 8;
    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SPREAD = 2'd2,
        OP_PICK   = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [1:0] CFG_GROUP_BASE  = 2'd0;
    localparam logic [1:0] CFG_GROUP_COUNT = 2'd1;
    localparam logic [1:0] CFG_GROUP_LIMIT = 2'd2;
    localparam logic [1:0] CFG_OTHER_LIMIT = 2'd3;

    // configuration reset values
    localparam logic [2:0] GROUP_BASE_RST  = 3'd0;
    localparam logic [3:0] GROUP_COUNT_RST = 4'd8;
    localparam logic [4:0] GROUP_LIMIT_RST = 5'd16;
    localparam logic [4:0] OTHER_LIMIT_RST = 5'd16;

endpackage

/* rtl/core/fifo_bank_round_robin_spread.sv */
// top level of the bank of bounded fifo queues with spread and pick
// A bank of NUM_QUEUES ring queues of DEPTH words each. Words live in one entry ram and
// the head pointer and fill count of every queue in a descriptor ram; descriptors never
// written read as empty through a valid bit per queue, so no clearing pass follows reset.
// One item is worked on at a time and the input stalls until its result is registered.
// Push and pop each run through a load and an execute state, pop adding a wait for the entry
// read; spread and pick add one group step per word spread or per member a pick visits
// (descriptor read, entry read, entry and descriptor write), and a pick member found empty
// skips the write. The next item is taken while a result
// still waits on the output.
module fifo_bank_round_robin_spread
    import fbrr_pkg::*;
#(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_queue_sel,
    input  logic [31:0] i_data_in,
    input  logic [4:0]  i_amount,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_data_out,
    output logic        o_data_valid,
    output logic        o_accepted,
    output logic [4:0]  o_moved,
    output logic [4:0]  o_dropped,
    output logic [4:0]  o_size_after,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = QW + PW;
    localparam int DW = PW + CW;
    localparam logic [QW-1:0] QMAX = QW'(NUM_QUEUES - 1);
    localparam logic [PW-1:0] HMAX = PW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_EXEC, S_POPW, S_RDO, S_CHK, S_MOV, S_DONE
    } t_state;

    // selected queue index modulo the bank size
    function automatic logic [QW-1:0] qmod(input logic [2:0] s);
        logic [6:0] v;
        v = {4'b0, s};
        for (int k = 0; k < 4; k++) begin
            if (v >= 7'(NUM_QUEUES)) begin
                v = v - 7'(NUM_QUEUES);
            end
        end
        return QW'(v);
    endfunction

    function automatic logic [QW-1:0] minc(input logic [QW-1:0] m);
        return (m == QMAX) ? '0 : m + 1'b1;
    endfunction

    function automatic logic [PW-1:0] hinc(input logic [PW-1:0] h);
        return (h == HMAX) ? '0 : h + 1'b1;
    endfunction

    // ring slot after the last word
    function automatic logic [PW-1:0] tail(input logic [PW-1:0] h, input logic [CW-1:0] f);
        logic [PW:0] s;
        s = (PW+1)'(h) + (PW+1)'(f);
        if (s >= (PW+1)'(DEPTH)) begin
            s = s - (PW+1)'(DEPTH);
        end
        return PW'(s);
    endfunction

    // size limit of a queue, by group membership
    function automatic logic [CW-1:0] cap_of(input logic [QW-1:0] x, input logic [QW-1:0] b,
                                             input logic [3:0] gc, input logic [4:0] gl,
                                             input logic [4:0] ol);
        int off;
        int lim;
        off = (int'(x) >= int'(b)) ? int'(x) - int'(b) : int'(x) + NUM_QUEUES - int'(b);
        lim = (off < int'(gc)) ? int'(gl) : int'(ol);
        if (lim >= 16 || lim > DEPTH) begin
            lim = DEPTH;
        end
        return CW'(lim);
    endfunction

    t_state              r_state;
    t_op                 r_op;
    logic [QW-1:0]       r_q;
    logic [WORD_WIDTH-1:0] r_data;
    logic [4:0]          r_amt;
    logic [2:0]          r_base;
    logic [3:0]          r_cnt;
    logic [4:0]          r_glim;
    logic [4:0]          r_olim;
    logic [QW-1:0]       r_bq;
    logic [PW-1:0]       r_ch;
    logic [CW-1:0]       r_cf;
    logic [PW-1:0]       r_oh;
    logic [CW-1:0]       r_of;
    logic [QW-1:0]       r_mem;
    logic [3:0]          r_gi;
    logic [4:0]          r_i;
    logic [4:0]          r_n;
    logic [4:0]          r_moved;
    logic [4:0]          r_dropped;
    logic [WORD_WIDTH-1:0] r_word;
    logic                r_pval;
    logic                r_acc;
    logic [NUM_QUEUES-1:0] r_dval;
    logic                r_rdv;
    logic                r_ov;
    logic [31:0]         r_odata;
    logic                r_odv;
    logic                r_oacc;
    logic [4:0]          r_omoved;
    logic [4:0]          r_odropped;
    logic [4:0]          r_osize;

    logic                d_we;
    logic [QW-1:0]       d_waddr;
    logic [DW-1:0]       d_wdata;
    logic [QW-1:0]       d_raddr;
    logic [DW-1:0]       d_rdata;
    logic [PW-1:0]       d_rh;
    logic [CW-1:0]       d_rf;
    logic                e_we;
    logic [EW-1:0]       e_waddr;
    logic [WORD_WIDTH-1:0] e_wdata;
    logic [EW-1:0]       e_raddr;
    logic [WORD_WIDTH-1:0] e_rdata;

    logic                in_acc;
    logic                is_spread;
    logic                same;
    logic [CW-1:0]       cap_q;
    logic [PW-1:0]       oth_h;
    logic [CW-1:0]       oth_f;
    logic [PW-1:0]       sh_n;
    logic [CW-1:0]       sf_n;
    logic [PW-1:0]       dh;
    logic [CW-1:0]       df;
    logic [CW-1:0]       cap_d;
    logic                mv_ok;
    logic [CW-1:0]       df_n;
    logic [PW-1:0]       n_ch;
    logic [CW-1:0]       n_cf;
    logic [4:0]          n_spread;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign {d_rh, d_rf} = d_rdata;
    assign is_spread   = (r_op == OP_SPREAD);
    assign same        = (r_mem == r_q);
    assign cap_q       = cap_of(r_q, r_bq, r_cnt, r_glim, r_olim);

    // descriptor of the group member, forwarded from the cache when it is the selected queue
    assign oth_h = same ? r_ch : (r_rdv ? d_rh : '0);
    assign oth_f = same ? r_cf : (r_rdv ? d_rf : '0);

    // one move: pop the source, then push onto the destination
    always_comb begin
        sh_n = is_spread ? hinc(r_ch) : hinc(r_oh);
        sf_n = is_spread ? r_cf - 1'b1 : r_of - 1'b1;
        if (same) begin
            dh = sh_n;
            df = sf_n;
        end else begin
            dh = is_spread ? r_oh : r_ch;
            df = is_spread ? r_of : r_cf;
        end
        cap_d = is_spread ? cap_of(r_mem, r_bq, r_cnt, r_glim, r_olim) : cap_q;
        mv_ok = (df < cap_d);
        df_n  = mv_ok ? df + 1'b1 : df;
        if (same || !is_spread) begin
            n_ch = dh;
            n_cf = df_n;
        end else begin
            n_ch = sh_n;
            n_cf = sf_n;
        end
    end

    // words a spread pops
    always_comb begin
        if (r_cnt == 4'd0) begin
            n_spread = '0;
        end else if (int'(r_amt) < int'(r_cf)) begin
            n_spread = r_amt;
        end else begin
            n_spread = 5'(r_cf);
        end
    end

    // ram port control
    always_comb begin
        d_raddr = (r_state == S_IDLE) ? qmod(i_queue_sel) : r_mem;
        d_we    = 1'b0;
        d_waddr = r_q;
        d_wdata = {r_ch, r_cf};
        e_we    = 1'b0;
        e_waddr = {r_q, tail(r_ch, r_cf)};
        e_wdata = r_data;
        e_raddr = {r_q, r_ch};
        unique case (r_state)
            S_EXEC: begin
                e_we = (r_op == OP_PUSH) && (r_cf < cap_q);
            end
            S_CHK: begin
                e_raddr = is_spread ? {r_q, r_ch} : {r_mem, oth_h};
            end
            S_MOV: begin
                e_we    = mv_ok;
                e_waddr = {(is_spread ? r_mem : r_q), tail(dh, df)};
                e_wdata = e_rdata;
                d_we    = !same;
                d_waddr = r_mem;
                d_wdata = is_spread ? {dh, df_n} : {sh_n, sf_n};
            end
            S_DONE: begin
                d_we = !(r_ov && i_out_stall);
            end
            default: begin
            end
        endcase
    end

    fbrr_ram #(
        .WIDTH(DW),
        .DEPTH(NUM_QUEUES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    fbrr_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(2 ** EW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dval  <= '0;
            r_rdv   <= 1'b0;
            r_ov    <= 1'b0;
            r_base  <= GROUP_BASE_RST;
            r_cnt   <= GROUP_COUNT_RST;
            r_glim  <= GROUP_LIMIT_RST;
            r_olim  <= OTHER_LIMIT_RST;
        end else begin
            r_rdv <= r_dval[d_raddr];
            if (d_we) begin
                r_dval[d_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GROUP_BASE:  r_base <= i_cfg_data[2:0];
                    CFG_GROUP_COUNT: r_cnt  <= i_cfg_data[3:0];
                    CFG_GROUP_LIMIT: r_glim <= i_cfg_data;
                    CFG_OTHER_LIMIT: r_olim <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= t_op'(i_op);
                        r_q       <= qmod(i_queue_sel);
                        r_data    <= WORD_WIDTH'(i_data_in);
                        r_amt     <= i_amount;
                        r_word    <= '0;
                        r_pval    <= 1'b0;
                        r_acc     <= 1'b0;
                        r_moved   <= '0;
                        r_dropped <= '0;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_ch    <= r_rdv ? d_rh : '0;
                    r_cf    <= r_rdv ? d_rf : '0;
                    r_bq    <= qmod(r_base);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_mem <= r_bq;
                    r_gi  <= '0;
                    r_i   <= '0;
                    r_n   <= n_spread;
                    unique case (r_op)
                        OP_PUSH: begin
                            if (r_cf < cap_q) begin
                                r_cf  <= r_cf + 1'b1;
                                r_acc <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        OP_POP: begin
                            if (r_cf != '0) begin
                                r_ch    <= hinc(r_ch);
                                r_cf    <= r_cf - 1'b1;
                                r_pval  <= 1'b1;
                                r_state <= S_POPW;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_state <= S_RDO;
                        end
                    endcase
                end
                S_POPW: begin
                    r_word  <= e_rdata;
                    r_state <= S_DONE;
                end
                S_RDO: begin
                    if (is_spread) begin
                        r_state <= (r_i == r_n) ? S_DONE : S_CHK;
                    end else begin
                        r_state <= (r_i == {1'b0, r_cnt} || r_cf >= cap_q) ? S_DONE : S_CHK;
                    end
                end
                S_CHK: begin
                    r_oh <= oth_h;
                    r_of <= oth_f;
                    if (!is_spread && oth_f == '0) begin
                        r_mem   <= minc(r_mem);
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RDO;
                    end else begin
                        r_state <= S_MOV;
                    end
                end
                S_MOV: begin
                    r_ch    <= n_ch;
                    r_cf    <= n_cf;
                    r_i     <= r_i + 1'b1;
                    r_moved <= r_moved + 1'b1;
                    if (is_spread) begin
                        if (!mv_ok) begin
                            r_dropped <= r_dropped + 1'b1;
                        end
                        if (r_gi + 1'b1 == r_cnt) begin
                            r_gi  <= '0;
                            r_mem <= r_bq;
                        end else begin
                            r_gi  <= r_gi + 1'b1;
                            r_mem <= minc(r_mem);
                        end
                    end else begin
                        r_mem <= minc(r_mem);
                    end
                    r_state <= S_RDO;
                end
                S_DONE: begin
                    if (!(r_ov && i_out_stall)) begin
                        r_ov       <= 1'b1;
                        r_odata    <= 32'(r_word);
                        r_odv      <= r_pval;
                        r_oacc     <= r_acc;
                        r_omoved   <= r_moved;
                        r_odropped <= r_dropped;
                        r_osize    <= (int'(r_cf) > 31) ? 5'd31 : 5'(r_cf);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_data_out   = r_odata;
    assign o_data_valid = r_odv;
    assign o_accepted   = r_oacc;
    assign o_moved      = r_omoved;
    assign o_dropped    = r_odropped;
    assign o_size_after = r_osize;

endmodule

/* rtl/core/fbrr_ram.sv */
// generic single-port-write ram with registered read
module fbrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fbrr_checker.sv */
// port-level checks of the queue bank, bound to the top level
module fbrr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_data_out,
    input logic        o_data_valid,
    input logic        o_accepted,
    input logic [4:0]  o_moved,
    input logic [4:0]  o_dropped
);

    // one item at a time: input stalls right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while another is at work");

    // a pushed item and a popped word never share a result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_data_valid && o_accepted))
        else $error("pop and push flags both set");

    // data is zero unless a word was popped
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_data_valid) |-> (o_data_out == 32'd0))
        else $error("data out without a popped word");

    // drops never exceed moved words
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dropped <= o_moved))
        else $error("more drops than moved words");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_data_out)))
        else $error("stalled result changed");

endmodule

bind fifo_bank_round_robin_spread fbrr_checker u_fbrr_checker (.*);

/* tb/tb_fifo_bank_round_robin_spread.sv */
// testbench of the queue bank: random and directed items checked against a behavioural model
`timescale 1ns / 100ps

import fbrr_pkg::*;

// expected result of one item
typedef struct {
    logic [31:0] data_out;
    logic        data_valid;
    logic        accepted;
    logic [4:0]  moved;
    logic [4:0]  dropped;
    logic [4:0]  size_after;
} t_res;

// behavioural queue bank and store of expected results
class bank_scoreboard;
    logic [31:0] words [8][16];
    int          head [8];
    int          fill [8];
    int          base, cnt, glim, olim;
    t_res        pending [$];
    int          errors;

    function new();
        for (int q = 0; q < 8; q++) begin
            head[q] = 0;
            fill[q] = 0;
        end
        base = GROUP_BASE_RST;
        cnt = GROUP_COUNT_RST;
        glim = GROUP_LIMIT_RST;
        olim = OTHER_LIMIT_RST;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] v);
        case (idx)
            CFG_GROUP_BASE:  base = v[2:0];
            CFG_GROUP_COUNT: cnt = v[3:0];
            CFG_GROUP_LIMIT: glim = v;
            default:         olim = v;
        endcase
    endfunction

    function int cap(int q);
        int lim;
        lim = (((q - base + 8) % 8) < cnt) ? glim : olim;
        return (lim >= 16) ? 16 : lim;
    endfunction

    function bit put(int q, logic [31:0] w);
        if (fill[q] >= cap(q)) return 0;
        words[q][(head[q] + fill[q]) % 16] = w;
        fill[q]++;
        return 1;
    endfunction

    function bit take(int q, output logic [31:0] w);
        w = '0;
        if (fill[q] == 0) return 0;
        w = words[q][head[q]];
        head[q] = (head[q] + 1) % 16;
        fill[q]--;
        return 1;
    endfunction

    // note an accepted input item
    function void note_item(t_op op, int q, logic [31:0] din, int amt);
        t_res r;
        logic [31:0] w;
        int n;
        r = '{default: '0};
        case (op)
            OP_PUSH: r.accepted = put(q, din);
            OP_POP: begin
                r.data_valid = take(q, w);
                r.data_out = w;
            end
            OP_SPREAD: begin
                if (cnt != 0) begin
                    n = (amt < fill[q]) ? amt : fill[q];
                    for (int i = 0; i < n; i++) begin
                        void'(take(q, w));
                        r.moved++;
                        if (!put((base + i % cnt) % 8, w)) r.dropped++;
                    end
                end
            end
            default: begin
                for (int i = 0; i < cnt && fill[q] < cap(q); i++) begin
                    if (take((base + i) % 8, w)) begin
                        r.moved++;
                        void'(put(q, w));
                    end
                end
            end
        endcase
        r.size_after = 5'(fill[q]);
        pending.push_back(r);
    endfunction

    function void report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endfunction

    // compare a result item with the oldest expectation
    function void check_result(t_res got);
        t_res e;
        if (pending.size() == 0) begin
            report("result with nothing expected");
            return;
        end
        e = pending.pop_front();
        if (got.data_out !== e.data_out) report("data_out");
        if (got.data_valid !== e.data_valid) report("data_valid");
        if (got.accepted !== e.accepted) report("accepted");
        if (got.moved !== e.moved) report("moved");
        if (got.dropped !== e.dropped) report("dropped");
        if (got.size_after !== e.size_after) report("size_after");
    endfunction
endclass

module tb_fifo_bank_round_robin_spread;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = '0;
    logic [2:0]  i_queue_sel = '0;
    logic [31:0] i_data_in = '0;
    logic [4:0]  i_amount = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_data_out;
    logic        o_data_valid;
    logic        o_accepted;
    logic [4:0]  o_moved;
    logic [4:0]  o_dropped;
    logic [4:0]  o_size_after;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data = '0;

    bank_scoreboard sb = new();
    bit stall_on = 1'b1;
    int out_wait = 0;

    fifo_bank_round_robin_spread dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver waits a drawn number of cycles per item, one result checked per accept
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result('{o_data_out, o_data_valid, o_accepted, o_moved, o_dropped,
                              o_size_after});
            out_wait = stall_on ? $urandom_range(0, 9) : 0;
        end else if (o_out_valid && out_wait > 0) begin
            out_wait--;
        end
        i_out_stall <= (out_wait > 0);
    end

    // send one item, waiting for acceptance
    task automatic send(t_op op, logic [2:0] q, logic [31:0] din, logic [4:0] amt);
        int gap;
        gap = stall_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_queue_sel <= q;
        i_data_in <= din;
        i_amount <= amt;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(op, q, din, amt);
    endtask

    // register write while the bank is idle
    task automatic write_reg(logic [1:0] idx, logic [4:0] v);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_group(int b, int c, int gl, int ol);
        write_reg(CFG_GROUP_BASE, 5'(b));
        write_reg(CFG_GROUP_COUNT, 5'(c));
        write_reg(CFG_GROUP_LIMIT, 5'(gl));
        write_reg(CFG_OTHER_LIMIT, 5'(ol));
    endtask

    // random item, push heavy so queues fill and spread has work
    task automatic random_item();
        int r;
        t_op op;
        r = $urandom_range(0, 99);
        op = (r < 45) ? OP_PUSH : (r < 70) ? OP_POP : (r < 88) ? OP_SPREAD : OP_PICK;
        send(op, 3'($urandom_range(0, 7)), $urandom(),
             5'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16)));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, empty pop, full push, spread and pick edges
        send(OP_POP, 3'd0, '0, '0);
        send(OP_SPREAD, 3'd0, '0, 5'd16);
        send(OP_PICK, 3'd7, '0, '0);
        for (int i = 0; i < 17; i++) send(OP_PUSH, 3'd7, (i == 0) ? 32'hFFFF_FFFF : i, '0);
        send(OP_SPREAD, 3'd7, '0, 5'd31);
        send(OP_PICK, 3'd7, '0, '0);
        send(OP_POP, 3'd7, '0, '0);
        send(OP_POP, 3'd0, '0, '0);

        // phases over several group settings, extremes among them
        for (int ph = 0; ph < 12; ph++) begin
            stall_on = (ph % 4 != 3);
            case (ph)
                0:  set_group(7, 0, 0, 0);
                1:  set_group(0, 15, 31, 16);
                2:  set_group(5, 3, 2, 4);
                3:  set_group(2, 1, 1, 16);
                default: set_group($urandom_range(0, 7), $urandom_range(0, 15),
                                   $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            for (int k = 0; k < 140; k++) random_item();
        end

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
